// ===== rtl/dtps_pkg.sv =====
// ----------------------------------------------------------------------------
// dtps_pkg
// Shared types and constants for the digraph two-path store.
// ----------------------------------------------------------------------------
package dtps_pkg;

  localparam int MAX_NODES  = 64;
  localparam int MAX_DEGREE = 64;
  localparam int NODE_W     = 6;
  localparam int SLOT_W     = 6;
  localparam int DEG_W      = 7;
  localparam int CNT_W      = 6;
  localparam int ARC_W      = 13;
  localparam int NC_W       = 7;
  localparam int TBL_AW     = 2 * NODE_W;
  localparam int TBL_DEPTH  = MAX_NODES * MAX_NODES;
  localparam int LIST_AW    = NODE_W + SLOT_W;
  localparam int LIST_DEPTH = MAX_NODES * MAX_DEGREE;

  localparam logic [NC_W-1:0] NODE_COUNT_RESET = NC_W'(MAX_NODES);
  localparam logic REG_NODE_COUNT = 1'b0;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_DUP   = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;
  localparam logic [1:0] STATUS_FULL  = 2'd3;

  typedef enum logic [1:0] {
    TBL_MIX,
    TBL_TGT,
    TBL_SRC
  } tbl_sel_t;

  typedef struct packed {
    logic              rd;
    logic              bump;
    logic              dec;
    tbl_sel_t          sel;
    logic [TBL_AW-1:0] addr;
  } tbl_req_t;

  typedef struct packed {
    logic             clearing;
    logic [CNT_W-1:0] mix;
    logic [CNT_W-1:0] tgt;
    logic [CNT_W-1:0] src;
  } tbl_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RANGE,
    ST_DEG0,
    ST_DEG1,
    ST_DEG2,
    ST_SRCH_RD,
    ST_SRCH_CK,
    ST_DECIDE,
    ST_INS,
    ST_REM_RD,
    ST_REM_WR,
    ST_RS_RD,
    ST_RS_CK,
    ST_RL_RD,
    ST_RL_WR,
    ST_REM_DONE,
    ST_WALK_RD,
    ST_WALK_V,
    ST_B_RD1,
    ST_B_WR1,
    ST_B_RD2,
    ST_B_WR2,
    ST_FIN_RD,
    ST_FIN_CK,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/digraph_two_path_store_core.sv =====
// ----------------------------------------------------------------------------
// digraph_two_path_store_core
// Directed graph store with incremental two-path and common-neighbor counts.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                      Direction
//   input     in_valid, in_ready, kind, from_node, to_node  into block
//   result    out_valid, out_ready, status ... arc_total     out of block
//   config    psel, penable, pwrite, paddr, pwdata, prdata   APB slave
//
// One item is handled at a time by a small sequencer. A look-up searches the
// out-list of from_node. An update adds the list edits and four neighbor-list
// walks, each entry that is not skipped bumping the tables once or, in the
// first two walks, twice. Each list memory and the table memories have a
// single write port.
// After reset the three pair tables are cleared entry by entry; in_ready
// stays low meanwhile, while configuration writes are taken as always.
// A result waits in its output register until out_ready; no new transfer is
// taken on the input until the result transfer completes.
//
module digraph_two_path_store_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [5:0]  from_node,
  input  logic [5:0]  to_node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        arc_present,
  output logic [5:0]  mix_count,
  output logic [5:0]  in_count,
  output logic [5:0]  out_count,
  output logic [6:0]  out_degree,
  output logic [6:0]  in_degree,
  output logic [12:0] arc_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW = dtps_pkg::NODE_W;
  localparam int SW = dtps_pkg::SLOT_W;
  localparam int DW = dtps_pkg::DEG_W;

  dtps_pkg::state_t   state, state_next;
  dtps_pkg::tbl_req_t treq;
  dtps_pkg::tbl_rsp_t trsp;

  // Neighbor lists and degree memories.
  logic [NW-1:0] ol_mem [dtps_pkg::LIST_DEPTH];
  logic [NW-1:0] il_mem [dtps_pkg::LIST_DEPTH];
  logic [DW-1:0] od_mem [dtps_pkg::MAX_NODES];
  logic [DW-1:0] id_mem [dtps_pkg::MAX_NODES];
  logic [dtps_pkg::MAX_NODES-1:0] od_vld, id_vld;

  logic [NW-1:0] ol_q, il_q;
  logic [DW-1:0] od_q, id_q;
  logic [dtps_pkg::LIST_AW-1:0] ol_ra, il_ra, ol_wa, il_wa;
  logic [NW-1:0] ol_wd, il_wd;
  logic          ol_we, il_we;
  logic [NW-1:0] od_ra, id_ra, od_wa, id_wa;
  logic [DW-1:0] od_wd, id_wd;
  logic          od_we, id_we;

  // Item context.
  logic [1:0]    kind_r;
  logic [NW-1:0] node_i, node_j, v;
  logic [DW-1:0] od_i, id_j, od_j, id_i;
  logic [DW-1:0] k;
  logic [SW-1:0] pos;
  logic [1:0]    walk;
  logic          phase, present, dec;
  logic [dtps_pkg::ARC_W-1:0] arc_counter;
  logic [dtps_pkg::NC_W-1:0]  node_count;

  // Derived values.
  logic [DW-1:0] limit, wdeg;
  logic          out_of_range, full, skip, two_bumps, use_out;
  logic [NW-1:0] wnode, wv;
  logic [DW-1:0] od_im1, id_jm1;
  logic [dtps_pkg::TBL_AW-1:0] addr1, addr2;
  dtps_pkg::tbl_sel_t wsel;

  dtps_tables u_tables (
    .clk (clk),
    .rst (rst),
    .req (treq),
    .rsp (trsp)
  );

  // Configuration port. Only one register, at word zero.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dtps_pkg::REG_NODE_COUNT) ?
                  {25'd0, node_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= dtps_pkg::NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == dtps_pkg::REG_NODE_COUNT) begin
      node_count <= pwdata[dtps_pkg::NC_W-1:0];
    end
  end

  // Node numbers must lie below the node count, capped at the table size.
  assign limit = (node_count > DW'(dtps_pkg::MAX_NODES)) ?
                 DW'(dtps_pkg::MAX_NODES) : node_count;
  assign out_of_range = ({1'b0, node_i} >= limit) || ({1'b0, node_j} >= limit);
  assign full = (od_i >= DW'(dtps_pkg::MAX_DEGREE)) ||
                (id_j >= DW'(dtps_pkg::MAX_DEGREE));
  assign od_im1 = od_i - DW'(1);
  assign id_jm1 = id_j - DW'(1);

  // The four walks: out-list of i, in-list of j, in-list of i, out-list of j.
  always_comb begin
    case (walk)
      2'd0: begin
        wdeg = od_i; wnode = node_i; use_out = 1'b1;
        addr1 = {v, node_j}; addr2 = {node_j, v}; wsel = dtps_pkg::TBL_SRC;
      end
      2'd1: begin
        wdeg = id_j; wnode = node_j; use_out = 1'b0;
        addr1 = {v, node_i}; addr2 = {node_i, v}; wsel = dtps_pkg::TBL_TGT;
      end
      2'd2: begin
        wdeg = id_i; wnode = node_i; use_out = 1'b0;
        addr1 = {v, node_j}; addr2 = {v, node_j}; wsel = dtps_pkg::TBL_MIX;
      end
      default: begin
        wdeg = od_j; wnode = node_j; use_out = 1'b1;
        addr1 = {node_i, v}; addr2 = {node_i, v}; wsel = dtps_pkg::TBL_MIX;
      end
    endcase
  end

  assign two_bumps = (walk == 2'd0) || (walk == 2'd1);
  assign wv        = use_out ? ol_q : il_q;
  assign skip      = (wv == node_i) || (wv == node_j);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dtps_pkg::ST_IDLE:     if (in_valid && in_ready) state_next = dtps_pkg::ST_RANGE;
      dtps_pkg::ST_RANGE:    state_next = out_of_range ? dtps_pkg::ST_OUT : dtps_pkg::ST_DEG0;
      dtps_pkg::ST_DEG0:     state_next = dtps_pkg::ST_DEG1;
      dtps_pkg::ST_DEG1:     state_next = dtps_pkg::ST_DEG2;
      dtps_pkg::ST_DEG2:     state_next = phase ? dtps_pkg::ST_WALK_RD : dtps_pkg::ST_SRCH_RD;
      dtps_pkg::ST_SRCH_RD:  state_next = (k == od_i) ? dtps_pkg::ST_DECIDE
                                                      : dtps_pkg::ST_SRCH_CK;
      dtps_pkg::ST_SRCH_CK:  state_next = (ol_q == node_j) ? dtps_pkg::ST_DECIDE
                                                           : dtps_pkg::ST_SRCH_RD;
      dtps_pkg::ST_DECIDE: begin
        case (kind_r)
          dtps_pkg::KIND_INSERT:
            state_next = (present || full) ? dtps_pkg::ST_FIN_RD : dtps_pkg::ST_INS;
          dtps_pkg::KIND_REMOVE:
            state_next = present ? dtps_pkg::ST_REM_RD : dtps_pkg::ST_FIN_RD;
          default:
            state_next = dtps_pkg::ST_FIN_RD;
        endcase
      end
      dtps_pkg::ST_INS:      state_next = dtps_pkg::ST_DEG0;
      dtps_pkg::ST_REM_RD:   state_next = dtps_pkg::ST_REM_WR;
      dtps_pkg::ST_REM_WR:   state_next = dtps_pkg::ST_RS_RD;
      dtps_pkg::ST_RS_RD:    state_next = (k == id_j) ? dtps_pkg::ST_REM_DONE
                                                      : dtps_pkg::ST_RS_CK;
      dtps_pkg::ST_RS_CK:    state_next = (il_q == node_i) ? dtps_pkg::ST_RL_RD
                                                           : dtps_pkg::ST_RS_RD;
      dtps_pkg::ST_RL_RD:    state_next = dtps_pkg::ST_RL_WR;
      dtps_pkg::ST_RL_WR:    state_next = dtps_pkg::ST_REM_DONE;
      dtps_pkg::ST_REM_DONE: state_next = dtps_pkg::ST_DEG0;
      dtps_pkg::ST_WALK_RD: begin
        if (k != wdeg) begin
          state_next = dtps_pkg::ST_WALK_V;
        end else if (walk == 2'd3) begin
          state_next = dtps_pkg::ST_FIN_RD;
        end
      end
      dtps_pkg::ST_WALK_V:   state_next = skip ? dtps_pkg::ST_WALK_RD : dtps_pkg::ST_B_RD1;
      dtps_pkg::ST_B_RD1:    state_next = dtps_pkg::ST_B_WR1;
      dtps_pkg::ST_B_WR1:    state_next = two_bumps ? dtps_pkg::ST_B_RD2
                                                    : dtps_pkg::ST_WALK_RD;
      dtps_pkg::ST_B_RD2:    state_next = dtps_pkg::ST_B_WR2;
      dtps_pkg::ST_B_WR2:    state_next = dtps_pkg::ST_WALK_RD;
      dtps_pkg::ST_FIN_RD:   state_next = dtps_pkg::ST_FIN_CK;
      dtps_pkg::ST_FIN_CK:   state_next = dtps_pkg::ST_OUT;
      dtps_pkg::ST_OUT:      if (out_ready) state_next = dtps_pkg::ST_IDLE;
      default:               state_next = dtps_pkg::ST_IDLE;
    endcase
  end

  // Memory and handshake controls for each state.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ol_ra = {node_i, k[SW-1:0]};
    il_ra = {node_j, k[SW-1:0]};
    ol_we = 1'b0; ol_wa = {node_i, pos}; ol_wd = ol_q;
    il_we = 1'b0; il_wa = {node_j, pos}; il_wd = il_q;
    od_ra = node_i; id_ra = node_j;
    od_we = 1'b0; od_wa = node_i; od_wd = od_im1;
    id_we = 1'b0; id_wa = node_j; id_wd = id_jm1;
    treq.rd   = 1'b0;
    treq.bump = 1'b0;
    treq.dec  = dec;
    treq.sel  = wsel;
    treq.addr = addr1;
    case (state)
      dtps_pkg::ST_IDLE: in_ready = !trsp.clearing;
      dtps_pkg::ST_DEG1: begin
        od_ra = node_j;
        id_ra = node_i;
      end
      dtps_pkg::ST_INS: begin
        ol_we = 1'b1; ol_wa = {node_i, od_i[SW-1:0]}; ol_wd = node_j;
        il_we = 1'b1; il_wa = {node_j, id_j[SW-1:0]}; il_wd = node_i;
        od_we = 1'b1; od_wd = od_i + DW'(1);
        id_we = 1'b1; id_wd = id_j + DW'(1);
      end
      dtps_pkg::ST_REM_RD: ol_ra = {node_i, od_im1[SW-1:0]};
      dtps_pkg::ST_REM_WR: begin
        ol_we = 1'b1;
        od_we = 1'b1;
      end
      dtps_pkg::ST_RL_RD: il_ra = {node_j, id_jm1[SW-1:0]};
      dtps_pkg::ST_RL_WR: begin
        il_we = 1'b1;
        id_we = 1'b1;
      end
      dtps_pkg::ST_WALK_RD: begin
        ol_ra = {wnode, k[SW-1:0]};
        il_ra = {wnode, k[SW-1:0]};
      end
      dtps_pkg::ST_B_RD1: treq.rd = 1'b1;
      dtps_pkg::ST_B_WR1: treq.bump = 1'b1;
      dtps_pkg::ST_B_RD2: begin
        treq.rd   = 1'b1;
        treq.addr = addr2;
      end
      dtps_pkg::ST_B_WR2: begin
        treq.bump = 1'b1;
        treq.addr = addr2;
      end
      dtps_pkg::ST_FIN_RD: begin
        treq.rd   = 1'b1;
        treq.addr = {node_i, node_j};
      end
      dtps_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  // Memories: registered reads, one write port each.
  always_ff @(posedge clk) begin
    ol_q <= ol_mem[ol_ra];
    il_q <= il_mem[il_ra];
    if (ol_we) begin
      ol_mem[ol_wa] <= ol_wd;
    end
    if (il_we) begin
      il_mem[il_wa] <= il_wd;
    end
    od_q <= od_vld[od_ra] ? od_mem[od_ra] : '0;
    id_q <= id_vld[id_ra] ? id_mem[id_ra] : '0;
    if (od_we) begin
      od_mem[od_wa] <= od_wd;
    end
    if (id_we) begin
      id_mem[id_wa] <= id_wd;
    end
  end

  // Degree entries read as zero until first written.
  always_ff @(posedge clk) begin
    if (rst) begin
      od_vld <= '0;
      id_vld <= '0;
    end else begin
      if (od_we) begin
        od_vld[od_wa] <= 1'b1;
      end
      if (id_we) begin
        id_vld[id_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dtps_pkg::ST_IDLE;
      arc_counter <= '0;
    end else begin
      state <= state_next;
      if (state == dtps_pkg::ST_INS) begin
        arc_counter <= arc_counter + 1'b1;
      end else if (state == dtps_pkg::ST_REM_DONE) begin
        arc_counter <= arc_counter - 1'b1;
      end
    end
  end

  // Item context and the result register.
  always_ff @(posedge clk) begin
    case (state)
      dtps_pkg::ST_IDLE: begin
        kind_r  <= kind;
        node_i  <= from_node;
        node_j  <= to_node;
        phase   <= 1'b0;
        present <= 1'b0;
        status  <= dtps_pkg::STATUS_DONE;
      end
      dtps_pkg::ST_RANGE: begin
        if (out_of_range) begin
          status      <= dtps_pkg::STATUS_RANGE;
          arc_present <= 1'b0;
          mix_count   <= '0;
          in_count    <= '0;
          out_count   <= '0;
          out_degree  <= '0;
          in_degree   <= '0;
          arc_total   <= arc_counter;
        end
      end
      dtps_pkg::ST_DEG1: begin
        od_i <= od_q;
        id_j <= id_q;
      end
      dtps_pkg::ST_DEG2: begin
        od_j <= od_q;
        id_i <= id_q;
        k    <= '0;
        walk <= 2'd0;
      end
      dtps_pkg::ST_SRCH_CK: begin
        if (ol_q == node_j) begin
          present <= 1'b1;
          pos     <= k[SW-1:0];
        end else begin
          k <= k + 1'b1;
        end
      end
      dtps_pkg::ST_DECIDE: begin
        if (kind_r == dtps_pkg::KIND_INSERT) begin
          if (present) begin
            status <= dtps_pkg::STATUS_DUP;
          end else if (full) begin
            status <= dtps_pkg::STATUS_FULL;
          end
        end else if (kind_r == dtps_pkg::KIND_REMOVE && !present) begin
          status <= dtps_pkg::STATUS_DUP;
        end
      end
      dtps_pkg::ST_INS: begin
        present <= 1'b1;
        dec     <= 1'b0;
        phase   <= 1'b1;
      end
      dtps_pkg::ST_REM_WR: k <= '0;
      dtps_pkg::ST_RS_CK: begin
        if (il_q == node_i) begin
          pos <= k[SW-1:0];
        end else begin
          k <= k + 1'b1;
        end
      end
      dtps_pkg::ST_REM_DONE: begin
        present <= 1'b0;
        dec     <= 1'b1;
        phase   <= 1'b1;
      end
      dtps_pkg::ST_WALK_RD: begin
        if (k == wdeg) begin
          walk <= walk + 1'b1;
          k    <= '0;
        end
      end
      dtps_pkg::ST_WALK_V: begin
        if (skip) begin
          k <= k + 1'b1;
        end else begin
          v <= wv;
        end
      end
      dtps_pkg::ST_B_WR1: begin
        if (!two_bumps) begin
          k <= k + 1'b1;
        end
      end
      dtps_pkg::ST_B_WR2: k <= k + 1'b1;
      dtps_pkg::ST_FIN_CK: begin
        arc_present <= present;
        mix_count   <= trsp.mix;
        in_count    <= trsp.tgt;
        out_count   <= trsp.src;
        out_degree  <= od_i;
        in_degree   <= id_j;
        arc_total   <= arc_counter;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/dtps_tables.sv =====
// ----------------------------------------------------------------------------
// dtps_tables
// The three node-pair count tables with a shared increment/decrement unit.
// ----------------------------------------------------------------------------
module dtps_tables (
  input  logic               clk,
  input  logic               rst,
  input  dtps_pkg::tbl_req_t req,
  output dtps_pkg::tbl_rsp_t rsp
);

  logic [dtps_pkg::CNT_W-1:0]  mix_mem [dtps_pkg::TBL_DEPTH];
  logic [dtps_pkg::CNT_W-1:0]  tgt_mem [dtps_pkg::TBL_DEPTH];
  logic [dtps_pkg::CNT_W-1:0]  src_mem [dtps_pkg::TBL_DEPTH];
  logic                        clearing;
  logic [dtps_pkg::TBL_AW-1:0] clr_ptr;
  logic [dtps_pkg::CNT_W-1:0]  mix_q, tgt_q, src_q, cur, upd;

  // After reset every entry is zeroed, one address per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_ptr  <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + 1'b1;
      if (clr_ptr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      mix_q <= mix_mem[req.addr];
      tgt_q <= tgt_mem[req.addr];
      src_q <= src_mem[req.addr];
    end
  end

  always_comb begin
    case (req.sel)
      dtps_pkg::TBL_MIX: cur = mix_q;
      dtps_pkg::TBL_TGT: cur = tgt_q;
      dtps_pkg::TBL_SRC: cur = src_q;
      default:           cur = mix_q;
    endcase
    upd = req.dec ? cur - dtps_pkg::CNT_W'(1) : cur + dtps_pkg::CNT_W'(1);
  end

  // A bump writes back the entry read in the previous cycle at the same address.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mix_mem[clr_ptr] <= '0;
      tgt_mem[clr_ptr] <= '0;
      src_mem[clr_ptr] <= '0;
    end else if (req.bump) begin
      case (req.sel)
        dtps_pkg::TBL_MIX: mix_mem[req.addr] <= upd;
        dtps_pkg::TBL_TGT: tgt_mem[req.addr] <= upd;
        dtps_pkg::TBL_SRC: src_mem[req.addr] <= upd;
        default: ;
      endcase
    end
  end

  assign rsp.clearing = clearing;
  assign rsp.mix      = mix_q;
  assign rsp.tgt      = tgt_q;
  assign rsp.src      = src_q;

endmodule
